FILE: rtl/esop_pkg.sv
// ============================================================================
// esop_pkg
// Shared types and codes for the elevator stop ordering block.
// ============================================================================
`default_nettype none

package esop_pkg;

    // Field widths fixed by the item formats
    localparam int unsigned LOAD_W   = 12;
    localparam int unsigned WEIGHT_W = 9;
    localparam int unsigned FLOOR_W  = 6;
    localparam int unsigned STATUS_W = 3;

    localparam logic [LOAD_W-1:0] LIMIT_RST = 12'd800;

    // Input operation codes
    typedef enum logic {
        FN_BOARD  = 1'b0,
        FN_DEPART = 1'b1
    } t_func;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADMIT = 3'd0,
        ST_OVER  = 3'd1,
        ST_FULL  = 3'd2,
        ST_STOP  = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/esop_ifs.sv
// ============================================================================
// esop_ifs
// Valid/ready channels for passenger/depart items and for result items.
// ============================================================================
`default_nettype none

interface esop_in_if
    import esop_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                func;
    logic [WEIGHT_W-1:0] weight_kg;
    logic [FLOOR_W-1:0]  dest_floor;
    logic                going_down;

    modport source (output valid, func, weight_kg, dest_floor, going_down, input ready);
    modport sink   (input valid, func, weight_kg, dest_floor, going_down, output ready);
endinterface

interface esop_out_if
    import esop_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LOAD_W-1:0]   load_kg;
    logic [FLOOR_W-1:0]  stop_floor;
    logic                last;

    modport source (output valid, status, load_kg, stop_floor, last, input ready);
    modport sink   (input valid, status, load_kg, stop_floor, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/elevator_stop_ordering.sv
// ============================================================================
// elevator_stop_ordering
// Admits passengers against a weight limit and emits their stops sorted.
// ============================================================================
// Usage:
//   i_item  : input items. func board adds one passenger (weight, floor);
//             func depart emits all stored stops in travel order.
//   o_res   : result items through a single output register. A board item
//             gives one result (admitted / overload / list full). A depart
//             gives one stop item per rider, last set on the final one, or a
//             single empty-trip item when no one boarded.
//   i_cfg_we/i_cfg_wdata : weight limit register, write only while idle.
// Timing:
//   Board: result registered in the cycle after accept; one item per cycle
//   while the output drains.
//   Depart with n riders: floors live in a one-read-port memory; each stop
//   is found by a full pass over the n entries (registered read) and then
//   emitted. No new item is taken meanwhile.
// Reset: synchronous, active low. Load and rider count go to zero, limit to
//   800. The floor memory is not cleared; only written slots are read.
// Stall: while a result waits unaccepted, no new item is taken and the
//   stop search holds in the emit state.
// ============================================================================
`default_nettype none

module elevator_stop_ordering
    import esop_pkg::*;
#(
    parameter int unsigned MAX_RIDERS = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [LOAD_W-1:0] i_cfg_wdata,
    esop_in_if.sink                i_item,
    esop_out_if.source             o_res
);

    localparam int unsigned IW = (MAX_RIDERS > 1) ? $clog2(MAX_RIDERS) : 1;
    localparam int unsigned CW = $clog2(MAX_RIDERS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RIDERS);

    // Control
    t_state                r_state, n_state;
    logic [LOAD_W-1:0]     r_limit;
    logic [LOAD_W-1:0]     r_load, n_load;
    logic [CW-1:0]         r_cnt, n_cnt;

    // Search pass
    logic [CW-1:0]         r_scan, n_scan;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic [FLOOR_W-1:0]    r_rd_data;
    logic [FLOOR_W-1:0]    r_best_val, n_best_val;
    logic [IW-1:0]         r_best_idx, n_best_idx;
    logic                  r_found, n_found;
    logic [MAX_RIDERS-1:0] r_done, n_done;     // stops already emitted
    logic [CW-1:0]         r_emit, n_emit;
    logic                  r_down, n_down;

    // Output register
    logic                  r_ov, n_ov;
    logic [STATUS_W-1:0]   r_st, n_st;
    logic [LOAD_W-1:0]     r_ld, n_ld;
    logic [FLOOR_W-1:0]    r_fl, n_fl;
    logic                  r_last, n_last;

    logic                  out_free;
    logic                  in_ready;
    logic                  in_fire;
    logic                  mem_we;
    logic                  rd_en;
    logic                  cand;
    logic [LOAD_W:0]       sum;

    // Floor store: one write port (boarding), one read port (search)
    logic [FLOOR_W-1:0]    mem [MAX_RIDERS];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cnt[IW-1:0]] <= i_item.dest_floor;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_scan[IW-1:0]];
        end
    end

    assign out_free = !r_ov || o_res.ready;
    assign in_ready = (r_state == S_IDLE) && out_free;
    assign in_fire  = i_item.valid && in_ready;
    assign sum      = {1'b0, r_load} + {{(LOAD_W + 1 - WEIGHT_W){1'b0}}, i_item.weight_kg};

    // Candidate test on returning read data; strict compare keeps the
    // earliest of equal floors, which is harmless since they are identical.
    assign cand = r_rd_vld && !r_done[r_rd_idx] &&
                  (!r_found || (r_down ? (r_rd_data > r_best_val)
                                       : (r_rd_data < r_best_val)));

    always_comb begin
        n_state    = r_state;
        n_load     = r_load;
        n_cnt      = r_cnt;
        n_scan     = r_scan;
        n_best_val = r_best_val;
        n_best_idx = r_best_idx;
        n_found    = r_found;
        n_done     = r_done;
        n_emit     = r_emit;
        n_down     = r_down;
        n_ov       = r_ov && !o_res.ready;
        n_st       = r_st;
        n_ld       = r_ld;
        n_fl       = r_fl;
        n_last     = r_last;
        mem_we     = 1'b0;
        rd_en      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_item.func == FN_BOARD) begin
                        n_ov   = 1'b1;
                        n_fl   = '0;
                        n_last = 1'b1;
                        n_ld   = r_load;
                        if (r_cnt >= MAX_CNT) begin
                            n_st = ST_FULL;
                        end else if (sum > {1'b0, r_limit}) begin
                            n_st = ST_OVER;
                        end else begin
                            mem_we = 1'b1;
                            n_cnt  = r_cnt + 1'b1;
                            n_load = sum[LOAD_W-1:0];
                            n_ld   = sum[LOAD_W-1:0];
                            n_st   = ST_ADMIT;
                        end
                    end else if (r_cnt == '0) begin
                        n_ov   = 1'b1;
                        n_st   = ST_EMPTY;
                        n_ld   = '0;
                        n_fl   = '0;
                        n_last = 1'b1;
                        n_load = '0;
                    end else begin
                        n_down  = i_item.going_down;
                        n_scan  = '0;
                        n_found = 1'b0;
                        n_done  = '0;
                        n_emit  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_scan < r_cnt) begin
                    rd_en  = 1'b1;
                    n_scan = r_scan + 1'b1;
                end
                if (cand) begin
                    n_found    = 1'b1;
                    n_best_val = r_rd_data;
                    n_best_idx = r_rd_idx;
                end
                if (r_rd_vld && (CW'(r_rd_idx) + 1'b1 == r_cnt)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov               = 1'b1;
                    n_st               = ST_STOP;
                    n_ld               = '0;
                    n_fl               = r_best_val;
                    n_last             = (r_emit + 1'b1 == r_cnt);
                    n_done[r_best_idx] = 1'b1;
                    n_emit             = r_emit + 1'b1;
                    if (r_emit + 1'b1 == r_cnt) begin
                        n_cnt   = '0;
                        n_load  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_scan  = '0;
                        n_found = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= LIMIT_RST;
            r_load   <= '0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_load   <= n_load;
            r_cnt    <= n_cnt;
            r_ov     <= n_ov;
            r_rd_vld <= rd_en;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Payload and search registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_found    <= n_found;
        r_done     <= n_done;
        r_emit     <= n_emit;
        r_down     <= n_down;
        r_st       <= n_st;
        r_ld       <= n_ld;
        r_fl       <= n_fl;
        r_last     <= n_last;
        if (rd_en) begin
            r_rd_idx <= r_scan[IW-1:0];
        end
    end

    assign i_item.ready     = in_ready;
    assign o_res.valid      = r_ov;
    assign o_res.status     = r_st;
    assign o_res.load_kg    = r_ld;
    assign o_res.stop_floor = r_fl;
    assign o_res.last       = r_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("rider count above capacity");

    a_done_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ($countones(r_done) == int'(r_emit)))
        else $error("emitted mask out of step with emit count");

    a_emit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_found)
        else $error("search pass ended without a stop");

    a_trip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_state == S_IDLE) |=> (r_cnt == '0 && r_load == '0))
        else $error("trip end did not clear list and load");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the elevator stop ordering block: a car model
// predicts admit/refuse results for each passenger and the sorted stop list
// for each departure; every result item is checked field by field.
// ============================================================================

module tb_top
    import esop_pkg::*;
;

    localparam int CAR_SIZE = 10;  // riders per trip, matches the DUT parameter

    // One expected result item
    typedef struct packed {
        t_status             status;
        logic [LOAD_W-1:0]   load_kg;
        logic [FLOOR_W-1:0]  stop_floor;
        logic                last;
    } t_car_outcome;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [LOAD_W-1:0] i_cfg_wdata;

    esop_in_if  in_ch ();
    esop_out_if out_ch ();

    elevator_stop_ordering #(
        .MAX_RIDERS (CAR_SIZE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (in_ch),
        .o_res       (out_ch)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Car model: limit, load and the stored floors of the current trip
    // ------------------------------------------------------------------------
    logic [LOAD_W-1:0]  car_limit = LIMIT_RST;
    logic [LOAD_W-1:0]  car_load  = '0;
    int                 car_riders = 0;
    logic [FLOOR_W-1:0] car_floors [CAR_SIZE];
    t_car_outcome       car_outcomes [$];   // results still owed by the DUT

    int err_count  = 0;
    int items_sent = 0;
    bit idle_on    = 1'b1;   // random gaps on both sides
    int long_hold  = 0;      // receiver hold-off request, in cycles

    function automatic t_car_outcome outcome(input t_status st,
                                             input logic [LOAD_W-1:0] load,
                                             input logic [FLOOR_W-1:0] fl,
                                             input logic lst);
        t_car_outcome r;
        r.status     = st;
        r.load_kg    = load;
        r.stop_floor = fl;
        r.last       = lst;
        return r;
    endfunction

    // Work out the results of one accepted item and queue them.
    task automatic car_step(input t_func fn, input logic [WEIGHT_W-1:0] w,
                            input logic [FLOOR_W-1:0] dest, input logic down);
        logic [FLOOR_W-1:0] trip [CAR_SIZE];
        logic [FLOOR_W-1:0] v;
        int                 i, j;
        t_status            st;
        if (fn == FN_BOARD) begin
            // full list is tested before weight
            if (car_riders >= CAR_SIZE) begin
                st = ST_FULL;
            end else if (int'(car_load) + int'(w) > int'(car_limit)) begin
                st = ST_OVER;
            end else begin
                car_floors[car_riders] = dest;
                car_riders++;
                car_load = car_load + LOAD_W'(w);
                st = ST_ADMIT;
            end
            car_outcomes.push_back(outcome(st, car_load, '0, 1'b1));
        end else if (car_riders == 0) begin
            car_load = '0;
            car_outcomes.push_back(outcome(ST_EMPTY, '0, '0, 1'b1));
        end else begin
            for (i = 0; i < car_riders; i++) trip[i] = car_floors[i];
            // insertion sort; direction picks the order
            for (i = 1; i < car_riders; i++) begin
                v = trip[i];
                j = i;
                while (j > 0 && (down ? trip[j-1] < v : trip[j-1] > v)) begin
                    trip[j] = trip[j-1];
                    j--;
                end
                trip[j] = v;
            end
            for (i = 0; i < car_riders; i++)
                car_outcomes.push_back(outcome(ST_STOP, '0, trip[i],
                                               i == car_riders - 1));
            car_riders = 0;
            car_load   = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        err_count++;
        $display("%0t ns: ERROR %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : check_results
        t_car_outcome want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (car_outcomes.size() == 0) begin
                report_error($sformatf("result with nothing pending, status %0d floor %0d",
                                       out_ch.status, out_ch.stop_floor));
            end else begin
                want = car_outcomes.pop_front();
                if (out_ch.status !== want.status)
                    report_error($sformatf("status got %0d want %0d",
                                           out_ch.status, want.status));
                if (out_ch.load_kg !== want.load_kg)
                    report_error($sformatf("load_kg got %0d want %0d",
                                           out_ch.load_kg, want.load_kg));
                if (out_ch.stop_floor !== want.stop_floor)
                    report_error($sformatf("stop_floor got %0d want %0d",
                                           out_ch.stop_floor, want.stop_floor));
                if (out_ch.last !== want.last)
                    report_error($sformatf("last got %0b want %0b",
                                           out_ch.last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold > 0) begin
                long_hold--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item sender. valid stays high between back-to-back items; it drops
    // only for a gap or a drain, so it never gets two updates in one step.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_func fn, input logic [WEIGHT_W-1:0] w,
                             input logic [FLOOR_W-1:0] dest, input logic down);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= fn;
        in_ch.weight_kg  <= w;
        in_ch.dest_floor <= dest;
        in_ch.going_down <= down;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        car_step(fn, w, dest, down);
        items_sent++;
    endtask

    // Unused fields carry random values so every bit still toggles.
    task automatic board(input logic [WEIGHT_W-1:0] w, input logic [FLOOR_W-1:0] dest);
        send_item(FN_BOARD, w, dest, 1'($urandom_range(0, 1)));
    endtask

    task automatic depart(input logic down);
        send_item(FN_DEPART, WEIGHT_W'($urandom), FLOOR_W'($urandom), down);
    endtask

    // Stop sending and wait until every owed result has arrived.
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (car_outcomes.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Register write; only called with the block idle.
    task automatic set_weight_limit(input logic [LOAD_W-1:0] limit);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        car_limit = limit;
        @(posedge i_clk);
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight(input int profile);
        case (profile)
            0:       return WEIGHT_W'($urandom_range(0, 511));
            1:       return WEIGHT_W'($urandom_range(0, 60));
            2:       return ($urandom_range(0, 2) == 0) ? 9'd511 : 9'd0;
            default: return WEIGHT_W'($urandom_range(0, (car_limit / 6 > 511) ?
                                                        511 : car_limit / 6));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Departures with nobody aboard, both directions
    task automatic test_empty_departs();
        depart(1'b0);
        depart(1'b1);
    endtask

    // Weight extremes, load landing exactly on the limit, one kg over it
    task automatic test_boarding_limits();
        board(9'd0, 6'd0);
        board(9'd511, 6'd63);
        board(9'd289, 6'd17);   // load now exactly 800
        board(9'd1, 6'd40);     // refused: overload
        board(9'd0, 6'd5);      // weight 0 still fits
        depart(1'b0);
    endtask

    // Fill the list with repeated floors; the next rider is refused as full
    // even though the weight alone would also overload.
    task automatic test_full_list();
        logic [FLOOR_W-1:0] floors [CAR_SIZE];
        int i;
        floors = '{6'd7, 6'd7, 6'd63, 6'd0, 6'd30, 6'd7, 6'd0, 6'd63, 6'd12, 6'd30};
        for (i = 0; i < CAR_SIZE; i++) board(9'd80, floors[i]);
        board(9'd511, 6'd9);
        depart(1'b1);
    endtask

    // Limit lowered under the load already aboard: even weight 0 is refused
    task automatic test_limit_below_load();
        wait_drain();
        set_weight_limit(12'd4095);
        board(9'd511, 6'd1);
        board(9'd511, 6'd3);
        board(9'd511, 6'd2);
        wait_drain();
        set_weight_limit(12'd1000);
        board(9'd0, 6'd44);
        depart(1'b0);
    endtask

    // Receiver holds off for a long stretch while items keep coming, so the
    // output register fills and the input stalls behind it.
    task automatic test_output_backpressure();
        int i;
        wait_drain();
        set_weight_limit(12'd2000);
        long_hold = 70;
        for (i = 0; i < CAR_SIZE; i++) board(pick_weight(1), FLOOR_W'($urandom));
        depart(1'($urandom_range(0, 1)));
        long_hold = 40;
        board(pick_weight(1), FLOOR_W'($urandom));
        board(pick_weight(1), FLOOR_W'($urandom));
        wait_drain();
    endtask

    // Random trips: a run of boardings then a departure. Rider counts past
    // the list size and zero-rider trips give the refusal and empty cases.
    task automatic test_random_trips(input logic [LOAD_W-1:0] limit, input int n_items);
        int stop_at, riders, profile;
        bit spread;
        wait_drain();
        set_weight_limit(limit);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            riders  = $urandom_range(0, 13);
            profile = $urandom_range(0, 3);
            spread  = 1'($urandom_range(0, 1));
            // narrow floor set -> lots of duplicate stops
            repeat (riders)
                board(pick_weight(profile),
                      spread ? FLOOR_W'($urandom_range(0, 63))
                             : FLOOR_W'($urandom_range(0, 3) * 21));
            depart(1'($urandom_range(0, 1)));
            // now and then the sender waits for every result mid-phase
            if ($urandom_range(0, 15) == 0) wait_drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : run
        in_ch.valid      <= 1'b0;
        in_ch.func       <= FN_BOARD;
        in_ch.weight_kg  <= '0;
        in_ch.dest_floor <= '0;
        in_ch.going_down <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        i_rst_n          <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_departs();
        test_boarding_limits();
        test_full_list();
        test_limit_below_load();
        test_output_backpressure();

        test_random_trips(12'd800, 50);
        test_random_trips(12'd1600, 50);
        test_random_trips(12'd2000, 50);
        test_random_trips(12'd0, 40);
        test_random_trips(12'd4095, 50);
        test_random_trips(LOAD_W'($urandom), 50);
        // last stretch runs at full rate, no gaps on either side
        idle_on = 1'b0;
        test_random_trips(12'd800, 50);

        // leave room for stray results after the longest depart
        wait_drain();
        repeat (150) @(posedge i_clk);
        if (car_outcomes.size() != 0)
            report_error($sformatf("%0d results never arrived", car_outcomes.size()));
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
